// File: sv/clnw_pkg.sv
// ============================================================================
// clnw_pkg
// Shared types and constants for the character-LCD nibble writer.
// ============================================================================
package clnw_pkg;

    localparam int VALUE_W = 32;
    localparam int ROW_W   = 2;
    localparam int COL_W   = 6;
    localparam int NIB_W   = 4;
    localparam int BYTE_W  = 8;

    typedef logic [1:0] req_type_t;

    localparam req_type_t REQ_CMD    = 2'd0;
    localparam req_type_t REQ_CHAR   = 2'd1;
    localparam req_type_t REQ_NUM    = 2'd2;
    localparam req_type_t REQ_CURSOR = 2'd3;

    // set-ddram-address command base
    localparam logic [BYTE_W-1:0] CURSOR_BASE = 8'h80;
    // high nibble of ascii '0' .. '9'
    localparam logic [NIB_W-1:0]  ASCII_DIGIT_HI = 4'h3;

    // bin-to-bcd converter status
    typedef struct packed {
        logic busy;
        logic done;
        logic overflow;
    } conv_stat_t;

endpackage

// File: sv/clnw_bcd_conv.sv
// ============================================================================
// clnw_bcd_conv
// Bit-serial binary to bcd converter (shift and add-3), one bit per cycle.
// ============================================================================
module clnw_bcd_conv #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [clnw_pkg::VALUE_W-1:0]  value,
    output logic [4*MAX_DIGITS-1:0]       bcd,
    output clnw_pkg::conv_stat_t          stat
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(clnw_pkg::VALUE_W);

    logic [clnw_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]             bcd_reg, bcd_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic                         ovf_reg, ovf_next;
    logic [BCD_W-1:0]             adj;

    // add 3 to every digit of 5 or more before the doubling shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        if (start) begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            ovf_next  = 1'b0;
        end else if (busy_reg) begin
            // a bit shifted out of the top digit means more digits than kept
            bcd_next = {adj[BCD_W-2:0], bin_reg[clnw_pkg::VALUE_W-1]};
            ovf_next = ovf_reg | adj[BCD_W-1];
            bin_next = {bin_reg[clnw_pkg::VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(clnw_pkg::VALUE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        ovf_reg <= ovf_next;
    end

    assign bcd           = bcd_reg;
    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;

endmodule

// File: sv/char_lcd_nibble_writer.sv
// ============================================================================
// char_lcd_nibble_writer
// Turns character-LCD requests into 4-bit bus transfers, high nibble first.
// ============================================================================
// usage
//   s_ channel: one request word (req_type, value, row, column) per handshake.
//     command and character words send value[7:0]; a number word sends the
//     unsigned decimal text of value; a cursor word sends 0x80 + (row-1)*0x40
//     + (column-1), all modulo 256
//   m_ channel: one transfer word per handshake (reg_select, nibble, last);
//     last marks the final transfer of a request
//   one request at a time: s_ready is high only while the sequencer is idle,
//     but the final transfer sits in the output register, so the next request
//     is taken while that transfer still waits on m_ready
//   sequence of a request:
//     command, character, cursor: 2 transfers, high nibble then low nibble
//     number: the value first runs through the bit-serial bcd converter (32
//     input bits, one per cycle), then leading zero digits are dropped one
//     by one, and each digit is loaded and sent as high and low nibble
//   a stalled receiver simply holds the sequencer; no word is dropped
//   reset (aresetn low, synchronous) returns to idle and empties the output
// ============================================================================
module char_lcd_nibble_writer #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_req_type,
    input  logic [clnw_pkg::VALUE_W-1:0]        s_value,
    input  logic [clnw_pkg::ROW_W-1:0]          s_row,
    input  logic [clnw_pkg::COL_W-1:0]          s_column,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_reg_select,
    output logic [clnw_pkg::NIB_W-1:0]          m_nibble,
    output logic                                m_last
);

    localparam int DIG_W  = 4 * MAX_DIGITS;
    localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a request word
    localparam logic [2:0] ST_CONV  = 3'd1;  // bcd conversion running
    localparam logic [2:0] ST_SKIP  = 3'd2;  // dropping leading zero digits
    localparam logic [2:0] ST_DIGIT = 3'd3;  // loading next digit character
    localparam logic [2:0] ST_BYTE  = 3'd4;  // sending the two nibbles

    logic [2:0]                 state_reg, state_next;
    logic [clnw_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       rs_reg, rs_next;
    logic                       fin_reg, fin_next;     // this byte ends the request
    logic                       nib_sel_reg, nib_sel_next; // 0 high nibble, 1 low
    logic [DIG_W-1:0]           dig_reg, dig_next;     // digit shift register
    logic [DCNT_W-1:0]          dcnt_reg, dcnt_next;   // digits left in dig_reg
    logic                       ovf_reg, ovf_next;     // number wider than MAX_DIGITS

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic                       m_rs_reg, m_rs_next;
    logic [clnw_pkg::NIB_W-1:0] m_nib_reg, m_nib_next;
    logic                       m_last_reg, m_last_next;
    logic                       out_free;

    logic                       accept;
    logic                       conv_start;
    logic [DIG_W-1:0]           conv_bcd;
    clnw_pkg::conv_stat_t       conv_stat;

    logic [clnw_pkg::ROW_W-1:0]  row_m1;
    logic [clnw_pkg::BYTE_W-1:0] col_m1;
    logic [clnw_pkg::BYTE_W-1:0] cursor_cmd;
    logic [3:0]                  top_digit;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign top_digit = dig_reg[DIG_W-1 -: 4];

    // cursor command, wrapping modulo 256 for out-of-range rows and columns
    assign row_m1     = s_row - clnw_pkg::ROW_W'(1);
    assign col_m1     = {2'b00, s_column} - clnw_pkg::BYTE_W'(1);
    assign cursor_cmd = clnw_pkg::CURSOR_BASE + {row_m1, 6'b000000} + col_m1;

    assign conv_start = accept && (s_req_type == clnw_pkg::REQ_NUM);

    clnw_bcd_conv #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .value   (s_value),
        .bcd     (conv_bcd),
        .stat    (conv_stat)
    );

    always_comb begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        rs_next      = rs_reg;
        fin_next     = fin_reg;
        nib_sel_next = nib_sel_reg;
        dig_next     = dig_reg;
        dcnt_next    = dcnt_reg;
        ovf_next     = ovf_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_rs_next    = m_rs_reg;
        m_nib_next   = m_nib_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    nib_sel_next = 1'b0;
                    fin_next     = 1'b1;
                    unique case (s_req_type)
                        clnw_pkg::REQ_CMD, clnw_pkg::REQ_CHAR: begin
                            byte_next  = s_value[clnw_pkg::BYTE_W-1:0];
                            rs_next    = (s_req_type == clnw_pkg::REQ_CHAR);
                            state_next = ST_BYTE;
                        end
                        clnw_pkg::REQ_CURSOR: begin
                            byte_next  = cursor_cmd;
                            rs_next    = 1'b0;
                            state_next = ST_BYTE;
                        end
                        default: begin
                            // decimal number
                            state_next = ST_CONV;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                if (conv_stat.done) begin
                    dig_next   = conv_bcd;
                    dcnt_next  = DCNT_W'(MAX_DIGITS);
                    ovf_next   = conv_stat.overflow;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // leading zeros go only when the number fits; a lone zero stays
                if (!ovf_reg && top_digit == 4'd0 && dcnt_reg != DCNT_W'(1)) begin
                    dig_next  = dig_reg << 4;
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end else begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                byte_next    = {clnw_pkg::ASCII_DIGIT_HI, top_digit};
                rs_next      = 1'b1;
                fin_next     = (dcnt_reg == DCNT_W'(1));
                nib_sel_next = 1'b0;
                dig_next     = dig_reg << 4;
                dcnt_next    = dcnt_reg - DCNT_W'(1);
                state_next   = ST_BYTE;
            end
            ST_BYTE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rs_next    = rs_reg;
                    if (nib_sel_reg) begin
                        m_nib_next   = byte_reg[3:0];
                        m_last_next  = fin_reg;
                        nib_sel_next = 1'b0;
                        state_next   = fin_reg ? ST_IDLE : ST_DIGIT;
                    end else begin
                        m_nib_next   = byte_reg[7:4];
                        m_last_next  = 1'b0;
                        nib_sel_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            nib_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            nib_sel_reg <= nib_sel_next;
        end
        byte_reg   <= byte_next;
        rs_reg     <= rs_next;
        fin_reg    <= fin_next;
        dig_reg    <= dig_next;
        dcnt_reg   <= dcnt_next;
        ovf_reg    <= ovf_next;
        m_rs_reg   <= m_rs_next;
        m_nib_reg  <= m_nib_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_reg_select = m_rs_reg;
    assign m_nibble     = m_nib_reg;
    assign m_last       = m_last_reg;

    // converter finishes only while the sequencer waits on it
    a_conv_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_stat.done |-> state_reg == ST_CONV)
        else $error("bcd conversion finished outside conversion state");

    // while waiting, the converter is either running or just done
    a_conv_active: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CONV |-> (conv_stat.busy || conv_stat.done))
        else $error("sequencer waiting on an idle converter");

    // never load a digit with none left
    a_digit_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIGIT |-> dcnt_reg != '0)
        else $error("digit load with empty digit register");

    // the final low nibble goes out flagged last and frees the input side
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BYTE && nib_sel_reg && fin_reg && out_free)
        |=> (state_reg == ST_IDLE && m_valid && m_last))
        else $error("final transfer did not end the request");

    // a byte request goes straight to the nibble sender
    a_byte_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type != clnw_pkg::REQ_NUM) |=> state_reg == ST_BYTE)
        else $error("byte request did not start sending");

endmodule
